/* rtl/assert_macros.svh */
// assertion macros used by the frame skip controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever the trigger holds
`define ASSERT_IMPLIES(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("assertion failed: label");

// consequent must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed: label");

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

`endif

/* rtl/afsc_pkg.sv */
// types, constants and the skip pattern table of the frame skip controller
// no dependencies
package afsc_pkg;

   localparam int LEVELS_DEF = 12;
   localparam int LEVEL_W    = 4;
   localparam int CREDIT_W   = 6;
   localparam int SPEED_W    = 14;
   localparam int FRAME_W    = 32;
   localparam int UNIT_W     = 11;

   localparam logic [SPEED_W-1:0] FAST_TENTHS = 14'd995;
   localparam logic [SPEED_W-1:0] SLOW_TENTHS = 14'd800;
   localparam logic [LEVEL_W-1:0] CLOSE_LIMIT = 4'd8;

   localparam logic signed [UNIT_W-1:0] SPAN_TENTHS = 11'sd900;
   localparam logic signed [UNIT_W-1:0] DIV_STEP    = 11'sd50;
   localparam logic signed [UNIT_W-1:0] ONE         = 11'sd1;
   localparam logic signed [UNIT_W-1:0] TWO         = 11'sd2;
   localparam logic signed [UNIT_W-1:0] CREDIT_FULL = 11'sd3;

   localparam logic signed [CREDIT_W-1:0] CREDIT_RAISE = -6'sd2;
   localparam logic signed [CREDIT_W-1:0] CREDIT_MIN   = -6'sd19;
   localparam logic signed [CREDIT_W-1:0] CREDIT_MAX   = 6'sd2;

   // bit p of row l: skip the frame at phase p for level l
   localparam logic [LEVELS_DEF-1:0] SKIP_PATTERN [LEVELS_DEF] = '{
      12'b000000000000,
      12'b100000000000,
      12'b100000100000,
      12'b100010001000,
      12'b100100100100,
      12'b101001010010,
      12'b101010101010,
      12'b101101011010,
      12'b110110110110,
      12'b111011101110,
      12'b111110111110,
      12'b111111111110
   };

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_DIVIDE = 5'b00100,
      S_CREDIT = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] sum;
      logic                     negative;
   } unit_res_type;

endpackage

/* rtl/afsc_alu.sv */
// shared signed adder used by the arithmetic steps of the level update
// depends on afsc_pkg
module afsc_alu (
   input  logic signed [afsc_pkg::UNIT_W-1:0] op_a,
   input  logic signed [afsc_pkg::UNIT_W-1:0] op_b,
   output afsc_pkg::unit_res_type             res
);

   logic signed [afsc_pkg::UNIT_W-1:0] sum;

   assign sum          = op_a + op_b;
   assign res.sum      = sum;
   assign res.negative = sum[afsc_pkg::UNIT_W-1];

endmodule

/* rtl/auto_frame_skip_controller.sv */
// frame skip controller: the result of a beat is registered in finish, which waits under rsp
// stalls, and the next beat is taken no earlier than the cycle after, from idle; long case:
// remainder subtraction (50 tenths of deficit per step, plus a closing step) then the credit
// loop (one level raised per step, plus a closing step), on one shared adder; a waiting result
// holds the output register while the next beat is taken. reset (synchronous, active high)
// clears level, credit, phase, setting, fsm and rsp valid; uses afsc_pkg, afsc_alu, macros
`include "assert_macros.svh"

module auto_frame_skip_controller #(
   parameter int LEVELS = afsc_pkg::LEVELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [afsc_pkg::SPEED_W-1:0]     req_speed_tenths,
   input  logic                             req_new_frame,
   input  logic [afsc_pkg::FRAME_W-1:0]     req_frame_number,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_skip_next,
   output logic [afsc_pkg::LEVEL_W-1:0]     rsp_skip_level,
   input  logic                             csr_write_enable,
   input  logic [afsc_pkg::LEVEL_W-1:0]     csr_write_data
);

   localparam logic [afsc_pkg::LEVEL_W-1:0] TOP_LEVEL = afsc_pkg::LEVEL_W'(LEVELS - 1);
   localparam logic [afsc_pkg::LEVEL_W-1:0] AUTO_CODE = afsc_pkg::LEVEL_W'(LEVELS);
   localparam logic [afsc_pkg::FRAME_W-1:0] WARM_UP   = afsc_pkg::FRAME_W'(LEVELS << 1);

   afsc_pkg::state_type state_ff, state_in;

   logic [afsc_pkg::LEVEL_W-1:0]         setting_ff;
   logic [afsc_pkg::LEVEL_W-1:0]         level_ff, level_in;
   logic signed [afsc_pkg::CREDIT_W-1:0] credit_ff, credit_in;
   logic [afsc_pkg::LEVEL_W-1:0]         phase_ff, phase_in;
   logic [afsc_pkg::SPEED_W-1:0]         speed_ff, speed_in;
   logic                                 fresh_ff, fresh_in;
   logic                                 warm_ff, warm_in;
   logic signed [afsc_pkg::UNIT_W-1:0]   rem_ff, rem_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 skip_next_ff, skip_next_in;
   logic [afsc_pkg::LEVEL_W-1:0]         skip_level_ff, skip_level_in;

   logic [afsc_pkg::LEVEL_W-1:0]         phase_next;
   logic signed [afsc_pkg::UNIT_W-1:0]   alu_a, alu_b;
   afsc_pkg::unit_res_type               alu_res;

   afsc_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   assign phase_next = (phase_ff == TOP_LEVEL) ? '0 : afsc_pkg::LEVEL_W'(phase_ff + 4'd1);

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      credit_in     = credit_ff;
      phase_in      = phase_ff;
      speed_in      = speed_ff;
      fresh_in      = fresh_ff;
      warm_in       = warm_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff;
      skip_next_in  = skip_next_ff;
      skip_level_in = skip_level_ff;
      alu_a         = '0;
      alu_b         = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         afsc_pkg::S_IDLE: begin
            if (req_valid) begin
               speed_in = req_speed_tenths;
               fresh_in = req_new_frame;
               warm_in  = req_frame_number > WARM_UP;
               state_in = afsc_pkg::S_EVAL;
            end
         end
         afsc_pkg::S_EVAL: begin
            state_in = afsc_pkg::S_FINISH;
            if (fresh_ff) begin
               if (setting_ff == AUTO_CODE) begin
                  if (warm_ff) begin
                     if (speed_ff >= afsc_pkg::FAST_TENTHS) begin
                        alu_a = afsc_pkg::UNIT_W'(credit_ff);
                        alu_b = afsc_pkg::ONE;
                        if (alu_res.sum >= afsc_pkg::CREDIT_FULL) begin
                           credit_in = '0;
                           if (level_ff != '0) begin
                              level_in = afsc_pkg::LEVEL_W'(level_ff - 4'd1);
                           end
                        end else begin
                           credit_in = afsc_pkg::CREDIT_W'(alu_res.sum);
                        end
                     end else if (speed_ff < afsc_pkg::SLOW_TENTHS) begin
                        alu_a    = afsc_pkg::SPAN_TENTHS;
                        alu_b    = -(afsc_pkg::UNIT_W'(speed_ff));
                        rem_in   = alu_res.sum;
                        state_in = afsc_pkg::S_DIVIDE;
                     end else begin
                        if (level_ff < afsc_pkg::CLOSE_LIMIT) begin
                           alu_a     = afsc_pkg::UNIT_W'(credit_ff);
                           alu_b     = -afsc_pkg::ONE;
                           credit_in = afsc_pkg::CREDIT_W'(alu_res.sum);
                        end
                        state_in = afsc_pkg::S_CREDIT;
                     end
                  end
               end else if (setting_ff > AUTO_CODE) begin
                  level_in = TOP_LEVEL;
               end else begin
                  level_in = setting_ff;
               end
            end
         end
         afsc_pkg::S_DIVIDE: begin
            // one subtraction of 50 tenths per cycle, one unit of credit each
            alu_a = rem_ff;
            alu_b = -afsc_pkg::DIV_STEP;
            if (!alu_res.negative) begin
               rem_in    = alu_res.sum;
               credit_in = afsc_pkg::CREDIT_W'(credit_ff - 6'sd1);
            end else begin
               state_in = afsc_pkg::S_CREDIT;
            end
         end
         afsc_pkg::S_CREDIT: begin
            if (credit_ff <= afsc_pkg::CREDIT_RAISE) begin
               alu_a = afsc_pkg::UNIT_W'(credit_ff);
               alu_b = afsc_pkg::TWO;
               if (level_ff < TOP_LEVEL) begin
                  credit_in = afsc_pkg::CREDIT_W'(alu_res.sum);
                  level_in  = afsc_pkg::LEVEL_W'(level_ff + 4'd1);
               end else begin
                  credit_in = '0;
                  state_in  = afsc_pkg::S_FINISH;
               end
            end else begin
               state_in = afsc_pkg::S_FINISH;
            end
         end
         afsc_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               phase_in      = phase_next;
               skip_next_in  = afsc_pkg::SKIP_PATTERN[level_ff][phase_next];
               skip_level_in = level_ff;
               rsp_valid_in  = 1'b1;
               state_in      = afsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = afsc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afsc_pkg::S_IDLE;
         setting_ff   <= '0;
         level_ff     <= '0;
         credit_ff    <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         credit_ff    <= credit_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            setting_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      speed_ff      <= speed_in;
      fresh_ff      <= fresh_in;
      warm_ff       <= warm_in;
      rem_ff        <= rem_in;
      skip_next_ff  <= skip_next_in;
      skip_level_ff <= skip_level_in;
   end

   assign req_ready      = state_ff == afsc_pkg::S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_skip_next  = skip_next_ff;
   assign rsp_skip_level = skip_level_ff;

   `ASSERT_ALWAYS(level_in_range, clock, reset, level_ff <= TOP_LEVEL)
   `ASSERT_ALWAYS(phase_in_range, clock, reset, phase_ff <= TOP_LEVEL)
   `ASSERT_ALWAYS(credit_in_range, clock, reset, (credit_ff >= afsc_pkg::CREDIT_MIN) && (credit_ff <= afsc_pkg::CREDIT_MAX))
   `ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(idle_credit_settled, clock, reset, state_ff == afsc_pkg::S_IDLE, credit_ff > afsc_pkg::CREDIT_RAISE)

endmodule
